[rtl/mke_pkg.sv]
package mke_pkg;

  // Symbol pattern: left aligned, bit 6 is the first symbol, 1 = dash
  typedef struct packed {
    logic       valid;
    logic [2:0] len;
    logic [6:0] pat;
  } code_t;

  // Segment kinds that the controller asks the datapath to emit
  localparam logic [1:0] SEG_SYM    = 2'd0;  // key down, dot or dash
  localparam logic [1:0] SEG_GAP    = 2'd1;  // 1 dot-unit gap after a symbol
  localparam logic [1:0] SEG_LETTER = 2'd2;  // letter gap, closes the character
  localparam logic [1:0] SEG_WORD   = 2'd3;  // first half of a space

  localparam logic [2:0] DASH_UNITS       = 3'd3;
  localparam logic [2:0] LETTER_GAP_UNITS = 3'd3;
  localparam logic [2:0] SPACE_GAP_UNITS  = 3'd4;

  localparam logic [1:0] TBL_NONE   = 2'd0;
  localparam logic [1:0] TBL_LATIN1 = 2'd1;
  localparam logic [1:0] TBL_KOI8R  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       lookup;
    logic       advance;
    logic       emit;
    logic [1:0] seg;
  } dp_cmd_t;

  typedef struct packed {
    logic is_space;
    logic valid;
    logic final_sym;
    logic pro;
  } dp_status_t;

  function automatic code_t mk(input logic [2:0] len, input logic [6:0] pat);
    code_t r;
    r.valid = 1'b1;
    r.len   = len;
    r.pat   = pat;
    return r;
  endfunction

  // Case folding for the selected codeset, CR and LF become space
  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic [1:0] tsel);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end else if (tsel == TBL_LATIN1 && c inside {[8'hC0:8'hDE]} && c != 8'hD7) begin
      r = c + 8'h20;
    end else if (tsel == TBL_KOI8R && c >= 8'hE0) begin
      r = c - 8'h20;
    end else if (tsel == TBL_KOI8R && c == 8'hB3) begin
      r = 8'hA3;
    end
    if (r == 8'h0D || r == 8'h0A) begin
      r = 8'h20;
    end
    return r;
  endfunction

  function automatic code_t ascii_code(input logic [7:0] c);
    code_t r;
    r = '0;
    case (c)
      8'h61: r = mk(3'd2, 7'b0100000); // a
      8'h62: r = mk(3'd4, 7'b1000000);
      8'h63: r = mk(3'd4, 7'b1010000);
      8'h64: r = mk(3'd3, 7'b1000000);
      8'h65: r = mk(3'd1, 7'b0000000);
      8'h66: r = mk(3'd4, 7'b0010000);
      8'h67: r = mk(3'd3, 7'b1100000);
      8'h68: r = mk(3'd4, 7'b0000000);
      8'h69: r = mk(3'd2, 7'b0000000);
      8'h6A: r = mk(3'd4, 7'b0111000);
      8'h6B: r = mk(3'd3, 7'b1010000);
      8'h6C: r = mk(3'd4, 7'b0100000);
      8'h6D: r = mk(3'd2, 7'b1100000);
      8'h6E: r = mk(3'd2, 7'b1000000);
      8'h6F: r = mk(3'd3, 7'b1110000);
      8'h70: r = mk(3'd4, 7'b0110000);
      8'h71: r = mk(3'd4, 7'b1101000);
      8'h72: r = mk(3'd3, 7'b0100000);
      8'h73: r = mk(3'd3, 7'b0000000);
      8'h74: r = mk(3'd1, 7'b1000000);
      8'h75: r = mk(3'd3, 7'b0010000);
      8'h76: r = mk(3'd4, 7'b0001000);
      8'h77: r = mk(3'd3, 7'b0110000);
      8'h78: r = mk(3'd4, 7'b1001000);
      8'h79: r = mk(3'd4, 7'b1011000);
      8'h7A: r = mk(3'd4, 7'b1100000); // z
      8'h30: r = mk(3'd5, 7'b1111100);
      8'h31: r = mk(3'd5, 7'b0111100);
      8'h32: r = mk(3'd5, 7'b0011100);
      8'h33: r = mk(3'd5, 7'b0001100);
      8'h34: r = mk(3'd5, 7'b0000100);
      8'h35: r = mk(3'd5, 7'b0000000);
      8'h36: r = mk(3'd5, 7'b1000000);
      8'h37: r = mk(3'd5, 7'b1100000);
      8'h38: r = mk(3'd5, 7'b1110000);
      8'h39: r = mk(3'd5, 7'b1111000);
      8'h2C: r = mk(3'd6, 7'b1100110); // comma
      8'h2E: r = mk(3'd6, 7'b0101010); // period
      8'h3F: r = mk(3'd6, 7'b0011000); // question mark
      8'h21: r = mk(3'd6, 7'b1010110); // exclamation mark
      8'h2F: r = mk(3'd5, 7'b1001000); // slash
      8'h2D: r = mk(3'd6, 7'b1000010); // hyphen
      8'h5F: r = mk(3'd6, 7'b0011010); // underscore
      8'h3D: r = mk(3'd5, 7'b1000100); // equals
      8'h3A: r = mk(3'd6, 7'b1110000); // colon
      8'h3B: r = mk(3'd6, 7'b1010100); // semicolon
      8'h28: r = mk(3'd5, 7'b1011000); // open paren
      8'h29: r = mk(3'd6, 7'b1011010); // close paren
      8'h24: r = mk(3'd7, 7'b0001001); // dollar
      8'h2B: r = mk(3'd5, 7'b0101000); // plus
      8'h27: r = mk(3'd6, 7'b0111100); // apostrophe
      8'h22: r = mk(3'd6, 7'b0100100); // double quote
      8'h40: r = mk(3'd6, 7'b0110100); // at sign
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic code_t latin1_code(input logic [7:0] c);
    code_t r;
    r = '0;
    case (c)
      8'hE0, 8'hE1, 8'hE2: r = mk(3'd5, 7'b0110100);
      8'hE4:               r = mk(3'd4, 7'b0101000);
      8'hE7:               r = mk(3'd5, 7'b1010000);
      8'hE8, 8'hE9:        r = mk(3'd5, 7'b0010000);
      8'hEA:               r = mk(3'd5, 7'b1001000);
      8'hF6:               r = mk(3'd4, 7'b1110000);
      8'hFC:               r = mk(3'd4, 7'b0011000);
      default:             r = '0;
    endcase
    return r;
  endfunction

  function automatic code_t koi8r_code(input logic [7:0] c);
    code_t r;
    r = '0;
    case (c)
      8'hC1: r = mk(3'd2, 7'b0100000);
      8'hC2: r = mk(3'd4, 7'b1000000);
      8'hD7: r = mk(3'd3, 7'b0110000);
      8'hC7: r = mk(3'd3, 7'b1100000);
      8'hC4: r = mk(3'd3, 7'b1000000);
      8'hC5: r = mk(3'd1, 7'b0000000);
      8'hA3: r = mk(3'd1, 7'b0000000);
      8'hD6: r = mk(3'd4, 7'b0001000);
      8'hDA: r = mk(3'd4, 7'b1100000);
      8'hC9: r = mk(3'd2, 7'b0000000);
      8'hCA: r = mk(3'd4, 7'b0111000);
      8'hCB: r = mk(3'd3, 7'b1010000);
      8'hCC: r = mk(3'd4, 7'b0100000);
      8'hCD: r = mk(3'd2, 7'b1100000);
      8'hCE: r = mk(3'd2, 7'b1000000);
      8'hCF: r = mk(3'd3, 7'b1110000);
      8'hD0: r = mk(3'd4, 7'b0110000);
      8'hD2: r = mk(3'd3, 7'b0100000);
      8'hD3: r = mk(3'd3, 7'b0000000);
      8'hD4: r = mk(3'd1, 7'b1000000);
      8'hD5: r = mk(3'd3, 7'b0010000);
      8'hC6: r = mk(3'd4, 7'b0010000);
      8'hC8: r = mk(3'd4, 7'b0000000);
      8'hC3: r = mk(3'd4, 7'b1010000);
      8'hDE: r = mk(3'd4, 7'b1110000);
      8'hDB: r = mk(3'd4, 7'b1111000);
      8'hDD: r = mk(3'd4, 7'b1101000);
      8'hD9: r = mk(3'd4, 7'b1011000);
      8'hD8: r = mk(3'd4, 7'b1001000);
      8'hDC: r = mk(3'd5, 7'b0010000);
      8'hC0: r = mk(3'd4, 7'b0011000);
      8'hD1: r = mk(3'd4, 7'b0101000);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Code lookup on an already folded character
  function automatic code_t lookup_code(input logic [7:0] c, input logic [1:0] tsel);
    code_t r;
    r = '0;
    if (!c[7]) begin
      r = ascii_code(c);
    end else if (tsel == TBL_LATIN1) begin
      r = latin1_code(c);
    end else if (tsel == TBL_KOI8R) begin
      r = koi8r_code(c);
    end
    return r;
  endfunction

endpackage

[rtl/mke_ctrl.sv]
module mke_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mke_pkg::dp_status_t status,
  output mke_pkg::dp_cmd_t    cmd,
  output logic                busy
);
  import mke_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOK   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SYM    = 3'd3;
  localparam logic [2:0] ST_GAP    = 3'd4;
  localparam logic [2:0] ST_LET    = 3'd5;
  localparam logic [2:0] ST_SP2    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.lookup = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.is_space) begin
          cmd.emit   = 1'b1;
          cmd.seg    = SEG_WORD;
          state_next = ST_SP2;
        end else if (status.valid) begin
          state_next = ST_SYM;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SYM: begin
        cmd.emit = 1'b1;
        cmd.seg  = SEG_SYM;
        if (!status.final_sym || status.pro) begin
          state_next = ST_GAP;
        end else begin
          state_next = ST_LET;
        end
      end
      ST_GAP: begin
        cmd.emit    = 1'b1;
        cmd.seg     = SEG_GAP;
        cmd.advance = 1'b1;
        state_next  = status.final_sym ? ST_IDLE : ST_SYM;
      end
      ST_LET, ST_SP2: begin
        cmd.emit   = 1'b1;
        cmd.seg    = SEG_LETTER;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

[rtl/mke_datapath.sv]
module mke_datapath (
  input  logic                clk,
  input  logic                rst,
  input  mke_pkg::dp_cmd_t    cmd,
  output mke_pkg::dp_status_t status,
  input  logic [7:0]          char_code,
  input  logic                prosign,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_data,
  output logic                strobe,
  output logic                key_on,
  output logic [2:0]          units,
  output logic                unit_kind,
  output logic                last
);
  import mke_pkg::*;

  logic [1:0] high_table;
  logic [7:0] char_r;
  logic       pro_r;
  logic       space_r;
  logic       valid_r;
  logic [6:0] pat_r;
  logic [2:0] remain;
  logic [7:0] folded;
  code_t      code;

  assign folded = fold_char(char_r, high_table);
  assign code   = lookup_code(folded, high_table);

  always_ff @(posedge clk) begin
    if (rst) begin
      high_table <= TBL_NONE;
    end else if (cfg_we) begin
      high_table <= cfg_data;
    end
  end

  // Hold the character, then its code; shift the pattern one symbol per gap
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= char_code;
      pro_r  <= prosign;
    end
    if (cmd.lookup) begin
      space_r <= (folded == 8'h20);
      valid_r <= code.valid;
      pat_r   <= code.pat;
      remain  <= code.len;
    end else if (cmd.advance) begin
      pat_r  <= {pat_r[5:0], 1'b0};
      remain <= remain - 3'd1;
    end
  end

  assign status.is_space  = space_r;
  assign status.valid     = valid_r;
  assign status.final_sym = (remain == 3'd1);
  assign status.pro       = pro_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.seg)
        SEG_SYM: begin
          key_on    <= 1'b1;
          units     <= pat_r[6] ? DASH_UNITS : 3'd1;
          unit_kind <= 1'b0;
          last      <= 1'b0;
        end
        SEG_GAP: begin
          key_on    <= 1'b0;
          units     <= 3'd1;
          unit_kind <= 1'b0;
          last      <= (remain == 3'd1);
        end
        SEG_LETTER: begin
          key_on    <= 1'b0;
          units     <= LETTER_GAP_UNITS;
          unit_kind <= 1'b1;
          last      <= 1'b1;
        end
        default: begin
          key_on    <= 1'b0;
          units     <= SPACE_GAP_UNITS;
          unit_kind <= 1'b1;
          last      <= 1'b0;
        end
      endcase
    end
  end

endmodule

[rtl/morse_keyer_encoder_core.sv]
// Flow: the edge that takes start loads the character, then lookup, then decide; strobe is
// registered from each segment state's emit (a space emits its first half from decide itself).
// Busy from lookup to the last segment state; N segments (0 to 14); start taken only in idle.
// Reset (rst, synchronous): controller to idle, no strobe, high_table back to none.
// The receiver cannot stall: each segment shows on strobe for exactly one cycle.
module morse_keyer_encoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] char_code,
  input  logic       prosign,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  output logic       strobe,
  output logic       key_on,
  output logic [2:0] units,
  output logic       unit_kind,
  output logic       last
);
  import mke_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller: walks load, lookup, decide, then one segment per cycle.
  mke_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath: holds the table select, folds and looks up the character,
  // shifts the symbol pattern and registers each outgoing beat.
  mke_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .char_code (char_code),
    .prosign   (prosign),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .key_on    (key_on),
    .units     (units),
    .unit_kind (unit_kind),
    .last      (last)
  );

  // Segment lengths stay within one to four units
  a_units_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (units != 3'd0 && units <= 3'd4))
    else $error("segment length out of range");

  // A key-down beat never closes a character
  a_sym_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && key_on) |-> !last)
    else $error("symbol marked last");

  // Every symbol is followed by a gap beat in the next cycle
  a_sym_then_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && key_on) |=> (strobe && !key_on))
    else $error("symbol not followed by gap");

  // An accepted character keeps the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("start not taken");

endmodule

[sim/morse_keyer_encoder_core_tb.sv]
`timescale 1ns / 100ps

module morse_keyer_encoder_core_tb;
  import mke_pkg::*;

  // Kind of unit a segment is counted in
  localparam bit KIND_DOT  = 1'b0;
  localparam bit KIND_WORD = 1'b1;

  // Table selector value that the block must treat like "none"
  localparam logic [1:0] TBL_UNUSED = 2'd3;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  // Drain allowance: the first strobe comes after start, and busy lasts the whole character
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 500;

  typedef struct {
    bit       key_on;
    bit [2:0] units;
    bit       unit_kind;
    bit       last;
  } segment_t;

  // Keying predictor plus the queue of segments still owed by the block
  class segment_scoreboard;
    bit [1:0] high_table;
    segment_t owed[$];
    int       errors;
    int       chars_taken;
    int       chars_sounding;
    int       segs_checked;

    function new();
      high_table = TBL_NONE;
    endfunction

    // Fold case for the selected codeset; CR and LF turn into space
    function bit [7:0] fold(bit [7:0] c);
      bit [7:0] r;
      r = c;
      if (c >= "A" && c <= "Z") begin
        r = c + 8'h20;
      end else if (high_table == TBL_LATIN1 && c >= 8'hC0 && c <= 8'hDE && c != 8'hD7) begin
        r = c + 8'h20;
      end else if (high_table == TBL_KOI8R && c >= 8'hE0) begin
        r = c - 8'h20;
      end else if (high_table == TBL_KOI8R && c == 8'hB3) begin
        r = 8'hA3;
      end
      if (r == CH_CR || r == CH_LF) begin
        r = CH_SP;
      end
      return r;
    endfunction

    function string ascii_pattern(bit [7:0] c);
      case (c)
        "a": return ".-";      "b": return "-...";    "c": return "-.-.";
        "d": return "-..";     "e": return ".";       "f": return "..-.";
        "g": return "--.";     "h": return "....";    "i": return "..";
        "j": return ".---";    "k": return "-.-";     "l": return ".-..";
        "m": return "--";      "n": return "-.";      "o": return "---";
        "p": return ".--.";    "q": return "--.-";    "r": return ".-.";
        "s": return "...";     "t": return "-";       "u": return "..-";
        "v": return "...-";    "w": return ".--";     "x": return "-..-";
        "y": return "-.--";    "z": return "--..";
        "0": return "-----";   "1": return ".----";   "2": return "..---";
        "3": return "...--";   "4": return "....-";   "5": return ".....";
        "6": return "-....";   "7": return "--...";   "8": return "---..";
        "9": return "----.";
        ",": return "--..--";  ".": return ".-.-.-";  "?": return "..--..";
        "!": return "-.-.--";  "/": return "-..-.";   "-": return "-....-";
        "_": return "..--.-";  "=": return "-...-";   ":": return "---...";
        ";": return "-.-.-.";  "(": return "-.--.";   ")": return "-.--.-";
        "$": return "...-..-"; "+": return ".-.-.";   "'": return ".----.";
        "\"": return ".-..-."; "@": return ".--.-.";
        default: return "";
      endcase
    endfunction

    function string latin1_pattern(bit [7:0] c);
      case (c)
        8'hE0, 8'hE1, 8'hE2: return ".--.-";
        8'hE4:               return ".-.-";
        8'hE7:               return "-.-..";
        8'hE8, 8'hE9:        return "..-..";
        8'hEA:               return "-..-.";
        8'hF6:               return "---.";
        8'hFC:               return "..--";
        default:             return "";
      endcase
    endfunction

    function string koi8r_pattern(bit [7:0] c);
      case (c)
        8'hC1: return ".-";    8'hC2: return "-...";  8'hD7: return ".--";
        8'hC7: return "--.";   8'hC4: return "-..";   8'hC5: return ".";
        8'hA3: return ".";     8'hD6: return "...-";  8'hDA: return "--..";
        8'hC9: return "..";    8'hCA: return ".---";  8'hCB: return "-.-";
        8'hCC: return ".-..";  8'hCD: return "--";    8'hCE: return "-.";
        8'hCF: return "---";   8'hD0: return ".--.";  8'hD2: return ".-.";
        8'hD3: return "...";   8'hD4: return "-";     8'hD5: return "..-";
        8'hC6: return "..-.";  8'hC8: return "....";  8'hC3: return "-.-.";
        8'hDE: return "---.";  8'hDB: return "----";  8'hDD: return "--.-";
        8'hD9: return "-.--";  8'hD8: return "-..-";  8'hDC: return "..-..";
        8'hC0: return "..--";  8'hD1: return ".-.-";
        default: return "";
      endcase
    endfunction

    function string morse_for(bit [7:0] c);
      if (c == CH_NUL) return "";
      if (!c[7]) return ascii_pattern(c);
      if (high_table == TBL_LATIN1) return latin1_pattern(c);
      if (high_table == TBL_KOI8R) return koi8r_pattern(c);
      return "";
    endfunction

    function void owe(bit on, bit [2:0] len, bit kind, bit fin);
      segment_t s;
      s.key_on    = on;
      s.units     = len;
      s.unit_kind = kind;
      s.last      = fin;
      owed.push_back(s);
    endfunction

    // Note an accepted character and queue the segments it must produce
    function void take_char(bit [7:0] code, bit pro);
      bit [7:0] c;
      string    pat;
      int       owed_start;
      bit       fin;
      owed_start = owed.size();
      chars_taken++;
      c = fold(code);
      if (c == CH_SP) begin
        // space ignores the prosign flag
        owe(1'b0, SPACE_GAP_UNITS, KIND_WORD, 1'b0);
        owe(1'b0, LETTER_GAP_UNITS, KIND_WORD, 1'b1);
      end else begin
        pat = morse_for(c);
        for (int i = 0; i < pat.len(); i++) begin
          fin = (i == pat.len() - 1);
          // a symbol never carries last, only the gap or letter space after it
          owe(1'b1, (pat[i] == "-") ? DASH_UNITS : 3'd1, KIND_DOT, 1'b0);
          if (!fin || pro) owe(1'b0, 3'd1, KIND_DOT, fin);
        end
        if (pat.len() > 0 && !pro) owe(1'b0, LETTER_GAP_UNITS, KIND_WORD, 1'b1);
      end
      if (owed.size() > owed_start) chars_sounding++;
    endfunction

    // Compare one strobed segment with the oldest one owed
    function void check_segment(bit on, bit [2:0] len, bit kind, bit fin);
      segment_t s;
      if (owed.size() == 0) begin
        $error("unexpected segment key_on=%0b units=%0d unit_kind=%0b last=%0b",
               on, len, kind, fin);
        errors++;
        return;
      end
      s = owed.pop_front();
      segs_checked++;
      if (on !== s.key_on) begin
        $error("key_on: expected %0b, got %0b", s.key_on, on);
        errors++;
      end
      if (len !== s.units) begin
        $error("units: expected %0d, got %0d", s.units, len);
        errors++;
      end
      if (kind !== s.unit_kind) begin
        $error("unit_kind: expected %0b, got %0b", s.unit_kind, kind);
        errors++;
      end
      if (fin !== s.last) begin
        $error("last: expected %0b, got %0b", s.last, fin);
        errors++;
      end
    endfunction

    function void flag_missing();
      foreach (owed[i]) begin
        $error("missing segment key_on=%0b units=%0d unit_kind=%0b last=%0b",
               owed[i].key_on, owed[i].units, owed[i].unit_kind, owed[i].last);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [7:0] char_code;
  logic       prosign;
  logic       cfg_we;
  logic [1:0] cfg_data;
  logic       strobe;
  logic       key_on;
  logic [2:0] units;
  logic       unit_kind;
  logic       last;

  segment_scoreboard board = new();
  bit no_idle;
  int table_writes;

  morse_keyer_encoder_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .char_code (char_code),
    .prosign   (prosign),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .key_on    (key_on),
    .units     (units),
    .unit_kind (unit_kind),
    .last      (last)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Segment monitor: a strobed segment is taken at the edge that ends its cycle,
  // so sample the pre-edge values right at the rising edge.
  always @(posedge clk) begin
    if (!rst && strobe) board.check_segment(key_on, units, unit_kind, last);
  end

  // Mostly short gaps, some long ones; none at all while a burst is running
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Bias toward characters with a keying pattern, keep full-byte noise in the mix
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom_range(0, 255));
      3: begin
        case ($urandom_range(0, 2))
          0:       return CH_SP;
          1:       return CH_CR;
          default: return CH_LF;
        endcase
      end
      4, 5:    return 8'($urandom_range(8'h41, 8'h5A));
      6, 7:    return 8'($urandom_range(8'h20, 8'h7E));
      default: return 8'($urandom_range(8'hA0, 8'hFF));
    endcase
  endfunction

  // Present one character, hold start until the beat is taken, then maybe idle.
  // Start is lowered only when a gap follows, so a back-to-back beat keeps it high.
  task automatic send_char(input logic [7:0] c, input logic pro);
    int gap;
    @(negedge clk);
    start     <= 1'b1;
    char_code <= c;
    prosign   <= pro;
    do @(posedge clk); while (busy);
    board.take_char(c, pro);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Wait for every owed segment and for busy to drop, then let a character
  // with no segments run out too. Bounded so a lost segment cannot hang here.
  task automatic drain();
    int n;
    n = 0;
    while ((board.owed.size() != 0 || busy) && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Select the high-code table; only done with the block idle
  task automatic load_table(input logic [1:0] sel);
    @(negedge clk);
    start <= 1'b0;
    drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= sel;
    board.high_table = sel;
    @(negedge clk);
    cfg_we <= 1'b0;
    table_writes++;
  endtask

  initial begin
    logic [1:0] phase_tables [5];
    int         k;

    rst       = 1'b1;
    start     = 1'b0;
    char_code = 8'h00;
    prosign   = 1'b0;
    cfg_we    = 1'b0;
    cfg_data  = 2'd0;
    no_idle   = 1'b0;
    table_writes = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: ASCII corners with no high table
    load_table(TBL_NONE);
    send_char("A", 1'b0);        // upper case folds down
    send_char("z", 1'b1);
    send_char(CH_NUL, 1'b0);     // code zero keys nothing
    send_char(8'hFF, 1'b0);      // high code with no table
    send_char(CH_SP, 1'b1);      // space ignores prosign
    send_char(CH_CR, 1'b1);
    send_char(CH_LF, 1'b0);
    send_char("$", 1'b0);        // longest pattern, seven symbols
    send_char("$", 1'b1);        // longest output, fourteen segments
    send_char("_", 1'b0);
    send_char(".", 1'b1);
    send_char(8'h80, 1'b0);

    // Latin-1: folding of the upper block, the multiply sign stays put
    load_table(TBL_LATIN1);
    send_char(8'hC0, 1'b0);
    send_char(8'hE9, 1'b1);
    send_char(8'hD7, 1'b0);
    send_char(8'hFC, 1'b0);

    // KOI8-R: folding runs the other way, plus the yo special case
    load_table(TBL_KOI8R);
    send_char(8'hE1, 1'b0);
    send_char(8'hB3, 1'b1);
    send_char(8'hA3, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'hD7, 1'b1);

    // Unused selector behaves as no table
    load_table(TBL_UNUSED);
    send_char(8'hE1, 1'b0);
    send_char("e", 1'b1);

    // Random phases over the tables, extremes included
    phase_tables = '{TBL_LATIN1, TBL_KOI8R, TBL_NONE, TBL_KOI8R, TBL_LATIN1};
    k = 0;
    foreach (phase_tables[p]) begin
      load_table(phase_tables[p]);
      repeat (95) begin
        // every fourth stretch of beats runs with no idle cycles
        no_idle = ((k / 24) % 4 == 3);
        send_char(pick_char(), ($urandom_range(0, 3) == 0));
        k++;
      end
    end
    no_idle = 1'b0;

    @(negedge clk);
    start <= 1'b0;
    drain();
    board.flag_missing();

    $display("Keyed %0d characters (%0d with segments), checked %0d segments",
             board.chars_taken, board.chars_sounding, board.segs_checked);
    $display("Table register written %0d times across none, Latin-1, KOI8-R and unused",
             table_writes);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
rtl/mke_pkg.sv
rtl/mke_ctrl.sv
rtl/mke_datapath.sv
rtl/morse_keyer_encoder_core.sv
sim/morse_keyer_encoder_core_tb.sv
